>>> rtl/core/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the modular square root block
// Data width, default iteration bound and the multiplier request and
// response records.
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

   localparam int DATA_W    = 64;
   localparam int MSR_WIDTH = 64;

   typedef struct packed {
      logic              go;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] m;
   } msr_mul_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] prod;
   } msr_mul_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/msr_mulmod.sv
// ----------------------------------------------------------------------------
// msr_mulmod: bit-serial modular multiplier
// Computes (x*y) mod m for x, y < m by double-and-add, at most one modular
// addition per cycle, taking the bits of y from the top one down.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_mulmod (
   input  wire                      clock,
   input  wire                      reset,
   input  msr_pkg::msr_mul_req_type req,
   output msr_pkg::msr_mul_rsp_type rsp
);
   import msr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [DATA_W-1:0] m_ff, m_in;
   logic [DATA_W-1:0] opnd;
   logic              add_en;
   logic [DATA_W:0]   sum;
   logic [DATA_W:0]   red;

   always_comb begin
      opnd   = cnt_ff[0] ? x_ff : acc_ff;
      add_en = !cnt_ff[0] || y_ff[DATA_W-1];
      sum    = {1'b0, acc_ff} + {1'b0, opnd};
      red    = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         m_in    = req.m;
      end else if (busy_ff) begin
         if (add_en) begin
            acc_in = red[DATA_W-1:0];
         end
         if (cnt_ff[0]) begin
            y_in = {y_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

`default_nettype wire

>>> rtl/core/modular_square_root.sv
// ----------------------------------------------------------------------------
// modular_square_root: Tonelli-Shanks modular square root
// Finds r with r*r == value mod modulus for an odd prime modulus, using one
// shared bit-serial modular multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                         tuser
//  req      in         [63:0] value, [127:64] mod    -
//  rsp      out        [63:0] root                   [0] found
//
// Modular products run one at a time on the shared multiplier; a request
// needs up to about 250 products for a 64-bit modulus 3 mod 4, many more
// for the Tonelli-Shanks path.
// One request is worked on at a time; req_tready is high only while idle.
// The result is held on rsp until it is taken. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_square_root #(
   parameter int WIDTH = msr_pkg::MSR_WIDTH
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,   // value [63:0], modulus [127:64]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,   // root [63:0]
   output logic [0:0]   rsp_tuser    // found [0]
);
   import msr_pkg::*;

   localparam int TW = $clog2(WIDTH * WIDTH + 1);
   localparam int RW = $clog2(WIDTH + 1);
   localparam logic [TW-1:0] TRY_MAX   = TW'(WIDTH * WIDTH);
   localparam logic [RW-1:0] ROUND_MAX = RW'(WIDTH);
   localparam logic [DATA_W-1:0] ONE   = DATA_W'(1);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_RED   = 14'b00000000000010,
      S_PSTEP = 14'b00000000000100,
      S_PMR   = 14'b00000000001000,
      S_PMB   = 14'b00000000010000,
      S_QS    = 14'b00000000100000,
      S_LOOP  = 14'b00000001000000,
      S_INNER = 14'b00000010000000,
      S_SQ    = 14'b00000100000000,
      S_CB    = 14'b00001000000000,
      S_TC    = 14'b00010000000000,
      S_RB    = 14'b00100000000000,
      S_OUT   = 14'b01000000000000,
      S_SPARE = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      R_EULER, R_P3, R_ZS, R_C, R_T, R_R, R_B
   } ret_type;

   state_type         state_ff, state_in;
   ret_type           ret_ff, ret_in;
   msr_mul_req_type   mreq_ff, mreq_in;
   msr_mul_rsp_type   mrsp;
   logic [DATA_W-1:0] a_ff, a_in, p_ff, p_in, half_ff, half_in, q_ff, q_in;
   logic [DATA_W-1:0] z_ff, z_in, c_ff, c_in, t_ff, t_in, r_ff, r_in;
   logic [DATA_W-1:0] tt_ff, tt_in, b_ff, b_in;
   logic [DATA_W-1:0] pw_r_ff, pw_r_in, pw_b_ff, pw_b_in, pw_e_ff, pw_e_in;
   logic [DATA_W-1:0] root_ff, root_in;
   logic              found_ff, found_in;
   logic [5:0]        s_ff, s_in, m_ff, m_in, i_ff, i_in;
   logic [TW-1:0]     tries_ff, tries_in;
   logic [RW-1:0]     rounds_ff, rounds_in;
   logic [DATA_W-1:0] value, modulus, z_next;
   logic [TW-1:0]     tries_next;
   logic [5:0]        i_next, sh;

   msr_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mreq_ff),
      .rsp   (mrsp)
   );

   assign value   = req_tdata[63:0];
   assign modulus = req_tdata[127:64];

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      mreq_in   = mreq_ff;
      mreq_in.go = 1'b0;
      a_in = a_ff;   p_in = p_ff;   half_in = half_ff; q_in = q_ff;
      z_in = z_ff;   c_in = c_ff;   t_in = t_ff;       r_in = r_ff;
      tt_in = tt_ff; b_in = b_ff;
      pw_r_in = pw_r_ff; pw_b_in = pw_b_ff; pw_e_in = pw_e_ff;
      root_in = root_ff; found_in = found_ff;
      s_in = s_ff; m_in = m_ff; i_in = i_ff;
      tries_in = tries_ff; rounds_in = rounds_ff;
      z_next     = z_ff + ONE;
      tries_next = tries_ff + TW'(1);
      i_next     = i_ff + 6'd1;
      sh         = m_ff - i_ff - 6'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               p_in = modulus;
               if (modulus < DATA_W'(3) || !modulus[0]) begin
                  root_in = '0; found_in = 1'b0; state_in = S_OUT;
               end else begin
                  mreq_in = '{go: 1'b1, x: ONE, y: value, m: modulus};
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            if (mrsp.done) begin
               a_in = mrsp.prod;
               if (mrsp.prod == '0) begin
                  root_in = '0; found_in = 1'b1; state_in = S_OUT;
               end else begin
                  half_in = (p_ff - ONE) >> 1;
                  pw_b_in = mrsp.prod; pw_e_in = (p_ff - ONE) >> 1; pw_r_in = ONE;
                  ret_in = R_EULER; state_in = S_PSTEP;
               end
            end
         end
         S_PSTEP: begin
            if (pw_e_ff == '0) begin
               case (ret_ff)
                  R_EULER: begin
                     if (pw_r_ff != ONE) begin
                        root_in = '0; found_in = 1'b0; state_in = S_OUT;
                     end else if (p_ff[1:0] == 2'b11) begin
                        pw_b_in = a_ff; pw_e_in = (p_ff >> 2) + ONE; pw_r_in = ONE;
                        ret_in = R_P3; state_in = S_PSTEP;
                     end else begin
                        q_in = p_ff - ONE; s_in = '0; state_in = S_QS;
                     end
                  end
                  R_P3: begin
                     root_in = pw_r_ff; found_in = 1'b1; state_in = S_OUT;
                  end
                  R_ZS: begin
                     if (pw_r_ff == p_ff - ONE) begin
                        m_in = s_ff;
                        pw_b_in = z_ff; pw_e_in = q_ff; pw_r_in = ONE;
                        ret_in = R_C; state_in = S_PSTEP;
                     end else if (z_next >= p_ff || tries_next >= TRY_MAX) begin
                        root_in = '0; found_in = 1'b0; state_in = S_OUT;
                     end else begin
                        z_in = z_next; tries_in = tries_next;
                        pw_b_in = z_next; pw_e_in = half_ff; pw_r_in = ONE;
                        state_in = S_PSTEP;
                     end
                  end
                  R_C: begin
                     c_in = pw_r_ff;
                     pw_b_in = a_ff; pw_e_in = q_ff; pw_r_in = ONE;
                     ret_in = R_T; state_in = S_PSTEP;
                  end
                  R_T: begin
                     t_in = pw_r_ff;
                     pw_b_in = a_ff; pw_e_in = (q_ff + ONE) >> 1; pw_r_in = ONE;
                     ret_in = R_R; state_in = S_PSTEP;
                  end
                  R_R: begin
                     r_in = pw_r_ff; rounds_in = '0; state_in = S_LOOP;
                  end
                  R_B: begin
                     b_in = pw_r_ff; m_in = i_ff;
                     mreq_in = '{go: 1'b1, x: pw_r_ff, y: pw_r_ff, m: p_ff};
                     state_in = S_CB;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else if (pw_e_ff[0]) begin
               mreq_in = '{go: 1'b1, x: pw_r_ff, y: pw_b_ff, m: p_ff};
               state_in = S_PMR;
            end else begin
               mreq_in = '{go: 1'b1, x: pw_b_ff, y: pw_b_ff, m: p_ff};
               state_in = S_PMB;
            end
         end
         S_PMR: begin
            if (mrsp.done) begin
               pw_r_in = mrsp.prod;
               mreq_in = '{go: 1'b1, x: pw_b_ff, y: pw_b_ff, m: p_ff};
               state_in = S_PMB;
            end
         end
         S_PMB: begin
            if (mrsp.done) begin
               pw_b_in = mrsp.prod; pw_e_in = pw_e_ff >> 1; state_in = S_PSTEP;
            end
         end
         S_QS: begin
            if (!q_ff[0] && s_ff != 6'd63) begin
               q_in = q_ff >> 1; s_in = s_ff + 6'd1;
            end else begin
               z_in = DATA_W'(2); tries_in = '0;
               pw_b_in = DATA_W'(2); pw_e_in = half_ff; pw_r_in = ONE;
               ret_in = R_ZS; state_in = S_PSTEP;
            end
         end
         S_LOOP: begin
            if (t_ff == ONE) begin
               root_in = r_ff; found_in = 1'b1; state_in = S_OUT;
            end else if (rounds_ff >= ROUND_MAX) begin
               root_in = '0; found_in = 1'b0; state_in = S_OUT;
            end else begin
               rounds_in = rounds_ff + RW'(1);
               i_in = '0; tt_in = t_ff; state_in = S_INNER;
            end
         end
         S_INNER: begin
            if (tt_ff == ONE) begin
               pw_b_in = c_ff; pw_e_in = ONE << sh; pw_r_in = ONE;
               ret_in = R_B; state_in = S_PSTEP;
            end else begin
               mreq_in = '{go: 1'b1, x: tt_ff, y: tt_ff, m: p_ff};
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (mrsp.done) begin
               tt_in = mrsp.prod;
               if (i_next >= m_ff) begin
                  root_in = '0; found_in = 1'b0; state_in = S_OUT;
               end else begin
                  i_in = i_next; state_in = S_INNER;
               end
            end
         end
         S_CB: begin
            if (mrsp.done) begin
               c_in = mrsp.prod;
               mreq_in = '{go: 1'b1, x: t_ff, y: mrsp.prod, m: p_ff};
               state_in = S_TC;
            end
         end
         S_TC: begin
            if (mrsp.done) begin
               t_in = mrsp.prod;
               mreq_in = '{go: 1'b1, x: r_ff, y: b_ff, m: p_ff};
               state_in = S_RB;
            end
         end
         S_RB: begin
            if (mrsp.done) begin
               r_in = mrsp.prod; state_in = S_LOOP;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mreq_ff.go <= 1'b0;
      end else begin
         state_ff <= state_in;
         mreq_ff  <= mreq_in;
      end
      ret_ff <= ret_in;
      a_ff <= a_in;   p_ff <= p_in;   half_ff <= half_in; q_ff <= q_in;
      z_ff <= z_in;   c_ff <= c_in;   t_ff <= t_in;       r_ff <= r_in;
      tt_ff <= tt_in; b_ff <= b_in;
      pw_r_ff <= pw_r_in; pw_b_ff <= pw_b_in; pw_e_ff <= pw_e_in;
      root_ff <= root_in; found_ff <= found_in;
      s_ff <= s_in; m_ff <= m_in; i_ff <= i_in;
      tries_ff <= tries_in; rounds_ff <= rounds_in;
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = (state_ff == S_OUT);
   assign rsp_tdata    = root_ff;
   assign rsp_tuser[0] = found_ff;

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> (state_ff == S_RED || state_ff == S_PMR || state_ff == S_PMB ||
                     state_ff == S_SQ || state_ff == S_CB || state_ff == S_TC ||
                     state_ff == S_RB))
      else $error("multiplier result arrived with no product pending");

   a_no_root_when_missing: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero root reported without a root");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a previous one is open");

   a_issue_only_idle_unit: assert property (@(posedge clock) disable iff (reset)
      mreq_ff.go |=> !mrsp.done)
      else $error("multiplier finished immediately after a start");

endmodule

`default_nettype wire

>>> verif/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker: result checker for the modular square root block
// Watches the request and result channels. Each accepted request is run
// through an independent Tonelli-Shanks predictor, and each accepted result
// is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [127:0] req_tdata,   // value [63:0], modulus [127:64]
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [63:0]  rsp_tdata,   // root [63:0]
   input  wire  [0:0]   rsp_tuser,   // found [0]
   output int           mismatches,
   output int           pending
);

   localparam int BOUND = msr_pkg::MSR_WIDTH;

   logic [63:0] root_q[$];
   logic        found_q[$];

   function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, x} * {64'd0, y};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      r = 64'd1 % m;
      b = b % m;
      while (e != 0) begin
         if (e[0]) begin
            r = mul_mod(r, b, m);
         end
         b = mul_mod(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   // Returns {found, root}.
   function automatic logic [64:0] predict_root(logic [63:0] a, logic [63:0] p);
      logic [63:0] half, q, z, c, t, r, tt, b, tries;
      int unsigned s, m, i, rounds;
      if (p < 3 || !p[0]) begin
         return 65'd0;
      end
      a = a % p;
      if (a == 0) begin
         return {1'b1, 64'd0};
      end
      half = (p - 1) >> 1;
      if (pow_mod(a, half, p) != 1) begin
         return 65'd0;
      end
      if (p[1:0] == 2'b11) begin
         return {1'b1, pow_mod(a, (p >> 2) + 1, p)};
      end
      q = p - 1;
      s = 0;
      while (!q[0] && s < 63) begin
         q = q >> 1;
         s++;
      end
      z = 2;
      tries = 0;
      while (pow_mod(z, half, p) != p - 1) begin
         z++;
         tries++;
         if (z >= p || tries >= 64'(BOUND * BOUND)) begin
            return 65'd0;
         end
      end
      m = s;
      c = pow_mod(z, q, p);
      t = pow_mod(a, q, p);
      r = pow_mod(a, (q + 1) >> 1, p);
      rounds = 0;
      while (t != 1) begin
         if (rounds >= BOUND) begin
            return 65'd0;
         end
         rounds++;
         i = 0;
         tt = t;
         while (tt != 1) begin
            tt = mul_mod(tt, tt, p);
            i++;
            if (i >= m) begin
               return 65'd0;
            end
         end
         b = pow_mod(c, 64'd1 << (m - i - 1), p);
         m = i;
         c = mul_mod(b, b, p);
         t = mul_mod(t, c, p);
         r = mul_mod(r, b, p);
      end
      return {1'b1, r};
   endfunction

   initial mismatches = 0;

   always @(posedge clock) begin
      logic [64:0] pred;
      logic [63:0] exp_root;
      logic        exp_found;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pred = predict_root(req_tdata[63:0], req_tdata[127:64]);
            root_q.push_back(pred[63:0]);
            found_q.push_back(pred[64]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (root_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("msr_checker: unexpected result root=%h found=%b",
                           rsp_tdata, rsp_tuser);
               end
            end else begin
               exp_root  = root_q.pop_front();
               exp_found = found_q.pop_front();
               if (rsp_tdata !== exp_root || rsp_tuser[0] !== exp_found) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("msr_checker: expected root=%h found=%b, got root=%h found=%b",
                              exp_root, exp_found, rsp_tdata, rsp_tuser);
                  end
               end
            end
         end
      end
      pending = root_q.size();
   end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the modular square root block
// Sends directed requests (degenerate and even moduli, zero values, both
// prime classes, wide primes, composite moduli), then random requests made
// mostly of small primes and squares, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam longint unsigned CYCLE_LIMIT = 40_000_000;
   localparam int              NUM_RANDOM  = 120;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // value [63:0], modulus [127:64]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;       // root [63:0]
   logic [0:0]   rsp_tuser;       // found [0]

   int              mismatches;
   int              pending;
   bit              quiet = 1'b0;
   int              stall_left = 0;
   longint unsigned cycles = 0;

   modular_square_root i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   msr_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .mismatches(mismatches),
      .pending   (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(3) == 0) begin
         stall_left <= $urandom_range(5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic bit is_prime(int unsigned n);
      if (n < 2) begin
         return 1'b0;
      end
      for (int unsigned d = 2; d * d <= n; d++) begin
         if (n % d == 0) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [63:0] pick_prime(int unsigned hi);
      int unsigned n;
      do begin
         n = $urandom_range(hi, 3) | 1;
      end while (!is_prime(n));
      return 64'(n);
   endfunction

   task automatic send_request(logic [63:0] value, logic [63:0] modulus);
      if (!quiet && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tdata  <= {modulus, value};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [63:0] p, v, k;
      int          pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(64'd5, 64'd0);
      send_request(64'd5, 64'd1);
      send_request(64'd4, 64'd2);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
      send_request(64'd0, 64'd7);
      send_request(64'd7, 64'd7);
      send_request(64'd2, 64'd7);
      send_request(64'd3, 64'd7);
      send_request(64'd10, 64'd13);
      send_request(64'd2, 64'd17);
      send_request(64'd3, 64'd17);
      send_request(64'd9, 64'd65537);
      send_request(64'd3, 64'd65537);
      send_request(64'd1600, 64'd40961);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5);
      send_request(64'd4, 64'hFFFF_FFFF_FFFF_FFC5);
      send_request(64'd9, 64'h1FFF_FFFF_FFFF_FFFF);
      send_request(64'd4, 64'd9);
      send_request(64'd4, 64'd15);
      send_request(64'd4, 64'd21);
      send_request(64'd16, 64'd45);
      send_request(64'd1, 64'd3);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM - 20) begin
            quiet = 1'b1;
         end
         pick = $urandom_range(99);
         v    = {$urandom, $urandom};
         if (pick < 70) begin
            p = pick_prime(pick < 10 ? 32'd1 << 20 : 32'd4096);
            if (pick % 2 == 0) begin
               k = 64'($urandom) % p;
               v = (k * k) % p + p * 64'($urandom_range(32'hFFFF));
            end
         end else if (pick < 85) begin
            p = 64'($urandom_range(127, 3) | 1);
         end else if (pick < 95) begin
            p = {$urandom, $urandom} & ~64'd1;
         end else begin
            p = 64'($urandom_range(2));
         end
         send_request(v, p);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
